// ----- hdl/tdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared constants, types and the sequencer state for the trial division
// number classifier.
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int NUMBER_WIDTH = 16;
    localparam int COUNT_W      = 8;
    localparam int SQ_W         = 2 * NUMBER_WIDTH + 1;
    localparam int DIV_CNT_W    = $clog2(NUMBER_WIDTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic CMD_PRIME = 1'b0;
    localparam logic CMD_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_WAIT,
        S_DONE
    } tdc_state_t;

    typedef struct packed {
        logic                    done;
        logic [NUMBER_WIDTH-1:0] remainder;
    } div_stat_t;

endpackage

// ----- hdl/tdc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_div
// Restoring divider, one quotient bit per cycle; reports the remainder.
// ----------------------------------------------------------------------------
module tdc_div
    import tdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] dividend,
    input  logic [NUMBER_WIDTH-1:0] divisor,
    output div_stat_t               stat
);

    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUMBER_WIDTH-1:0] q_reg, q_next;
    logic [NUMBER_WIDTH-1:0] r_reg, r_next;
    logic [NUMBER_WIDTH-1:0] dsr_reg, dsr_next;
    logic [NUMBER_WIDTH:0]   shifted;
    logic [NUMBER_WIDTH:0]   trial;

    assign shifted = {r_reg, q_reg[NUMBER_WIDTH-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        dsr_next  = dsr_reg;
        if (start && !run_reg)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = dividend;
            r_next   = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            // keep the trial difference when it does not go negative
            r_next   = trial[NUMBER_WIDTH] ? shifted[NUMBER_WIDTH-1:0]
                                           : trial[NUMBER_WIDTH-1:0];
            q_next   = {q_reg[NUMBER_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUMBER_WIDTH - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done      = done_reg;
    assign stat.remainder = r_reg;

endmodule

// ----- hdl/trial_division_number_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_number_classifier
// Primality test and divisor count by trial division over a shared divider.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the single result has been shown. The result is on prime_flag,
// composite_flag and divisor_count from done until the next item is taken;
// done marks it for exactly one cycle, and it cannot be held off. Each trial
// divisor goes through the bit-serial restoring divider. Command 0 tries up
// to floor(sqrt(n)) - 1 divisors and stops at the first hit; command 1 tries
// floor(n/2) divisors.
module trial_division_number_classifier
    import tdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    command,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    done,
    output logic                    prime_flag,
    output logic                    composite_flag,
    output logic [COUNT_W-1:0]      divisor_count
);

    tdc_state_t state_reg, state_next;

    // item and loop registers
    logic                    cmd_reg, cmd_next;
    logic [NUMBER_WIDTH-1:0] n_reg, n_next;
    logic [NUMBER_WIDTH-1:0] d_reg, d_next;           // trial divisor
    logic [SQ_W-1:0]         sq_reg, sq_next;         // trial divisor squared
    logic [NUMBER_WIDTH-1:0] rem_reg, rem_next;       // last remainder
    logic [COUNT_W-1:0]      cnt_reg, cnt_next;       // running count
    logic                    found_reg, found_next;

    logic       go_on;
    logic       div_start;
    div_stat_t  div_stat;

    tdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .stat     (div_stat)
    );

    // Primality: keep trying while d*d <= n. Count: while d <= floor(n/2).
    always_comb
    begin
        if (cmd_reg == CMD_PRIME)
            go_on = (sq_reg <= SQ_W'(n_reg));
        else
            go_on = (d_reg <= (n_reg >> 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = go_on ? S_DIV_WAIT : S_DONE;
            S_DIV_WAIT:
                if (div_stat.done)
                begin
                    // a hit ends the primality test at once
                    if (cmd_reg == CMD_PRIME && div_stat.remainder == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_CHECK;
                end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        cmd_next   = cmd_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd_next   = command;
                    n_next     = number;
                    d_next     = (command == CMD_PRIME) ? NUMBER_WIDTH'(2)
                                                        : NUMBER_WIDTH'(1);
                    sq_next    = SQ_W'(4);
                    rem_next   = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            S_DIV_WAIT:
                if (div_stat.done)
                begin
                    rem_next = div_stat.remainder;
                    if (cmd_reg == CMD_PRIME)
                    begin
                        if (div_stat.remainder == '0)
                            found_next = 1'b1;
                        else
                        begin
                            // (d+1)^2 = d^2 + 2d + 1
                            sq_next = sq_reg + SQ_W'({d_reg, 1'b1});
                            d_next  = d_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // hold the count at its ceiling
                        if (div_stat.remainder == '0 && cnt_reg != COUNT_MAX)
                            cnt_next = cnt_reg + 1'b1;
                        d_next = d_reg + 1'b1;
                    end
                end
            default:
                ;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:     busy = 1'b0;
            S_CHECK:    div_start = go_on;
            S_DIV_WAIT: ;
            S_DONE:     done = 1'b1;
            default:    ;
        endcase
    end

    // Flags only for the primality test; zero and one are neither.
    assign prime_flag     = (cmd_reg == CMD_PRIME) && !found_reg &&
                            (n_reg >= NUMBER_WIDTH'(2));
    assign composite_flag = (cmd_reg == CMD_PRIME) && found_reg;
    assign divisor_count  = (cmd_reg == CMD_COUNT) ? cnt_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_PRIME;
            d_reg     <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            d_reg     <= d_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg  <= n_next;
        sq_reg <= sq_next;
    end

`ifndef SYNTHESIS
    // a result never carries both flags
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(prime_flag && composite_flag))
        else $error("prime and composite flags both set");

    // a counting item reports no flags
    a_count_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd_reg == CMD_COUNT) |-> (!prime_flag && !composite_flag))
        else $error("flags set on a counting item");

    // the result strobe lasts one cycle and frees the block
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done strobe not a single cycle");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // the divider only reports while the sequencer waits on it
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");
`endif

endmodule

// ----- dv/tdc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_checker
// Watches the item and result ports of the trial division classifier,
// predicts each result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module tdc_checker
    import tdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    command,
    input  logic [NUMBER_WIDTH-1:0] number,
    input  logic                    done,
    input  logic                    prime_flag,
    input  logic                    composite_flag,
    input  logic [COUNT_W-1:0]      divisor_count,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct packed {
        logic                    item_cmd;
        logic [NUMBER_WIDTH-1:0] item_num;
        logic                    prime;
        logic                    composite;
        logic [COUNT_W-1:0]      count;
    } outcome_t;

    outcome_t outcome_q[$];
    int       items_taken  = 0;
    int       results_seen = 0;
    int       fail_count   = 0;

    // Mirror of the block's working registers; not visible on the ports.
    logic [NUMBER_WIDTH-1:0] last_divisor   = '0;
    logic [NUMBER_WIDTH-1:0] last_remainder = '0;
    logic [COUNT_W-1:0]      last_tally     = '0;

    assign outstanding = items_taken - results_seen;
    assign mismatches  = fail_count;

    // Trial division: first hit up to sqrt(n) for the primality test,
    // full sweep of 1..n/2 with a saturating tally for the divisor count.
    function automatic outcome_t classify(input logic cmd,
                                          input logic [NUMBER_WIDTH-1:0] n);
        outcome_t    res;
        int unsigned d;
        int unsigned half;
        logic        found;
        res          = '0;
        res.item_cmd = cmd;
        res.item_num = n;
        found        = 1'b0;
        last_divisor   = '0;
        last_remainder = '0;
        if (cmd == CMD_PRIME)
        begin
            for (d = 2; (d * d <= n) && !found; d++)
            begin
                last_divisor   = d[NUMBER_WIDTH-1:0];
                last_remainder = NUMBER_WIDTH'(n % d);
                found          = (last_remainder == 0);
            end
            if (n >= 2)
            begin
                res.composite = found;
                res.prime     = !found;
            end
        end
        else
        begin
            half = 32'(n) >> 1;
            for (d = 1; d <= half; d++)
            begin
                last_divisor   = d[NUMBER_WIDTH-1:0];
                last_remainder = NUMBER_WIDTH'(n % d);
                if (last_remainder == 0 && res.count != COUNT_MAX)
                    res.count = res.count + 1'b1;
            end
            last_tally = res.count;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fail_count++;
    endtask

    // Retire the result first; busy is high while done is, so no new item is taken at that edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            outcome_q.delete();
            items_taken  <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with no item pending");
                else
                begin
                    want = outcome_q.pop_front();
                    results_seen <= results_seen + 1;
                    if (prime_flag !== want.prime)
                        report_mismatch($sformatf("cmd %0d n %0d prime_flag %b, want %b",
                            want.item_cmd, want.item_num, prime_flag, want.prime));
                    if (composite_flag !== want.composite)
                        report_mismatch($sformatf("cmd %0d n %0d composite_flag %b, want %b",
                            want.item_cmd, want.item_num, composite_flag, want.composite));
                    if (divisor_count !== want.count)
                        report_mismatch($sformatf("cmd %0d n %0d divisor_count %0d, want %0d",
                            want.item_cmd, want.item_num, divisor_count, want.count));
                end
            end
            if (start && !busy)
            begin
                outcome_q.push_back(classify(command, number));
                items_taken <= items_taken + 1;
            end
        end
    end

endmodule

// ----- dv/trial_division_number_classifier_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_number_classifier_test
// Drives directed and random classify items into the block in phases of
// different sender pacing; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module trial_division_number_classifier_test;
    import tdc_pkg::*;

    // Longest correct quiet stretch is one count item on 65535, which tries
    // 32767 trial divisors; STALL_LIMIT sits well above that before calling a hang.
    localparam int STALL_LIMIT      = 3_000_000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE  = 20;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    command;
    logic [NUMBER_WIDTH-1:0] number;
    logic                    done;
    logic                    prime_flag;
    logic                    composite_flag;
    logic [COUNT_W-1:0]      divisor_count;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int sender_idle_pct;

    // Sender idle percentage per random phase. The result side cannot
    // stall, so the third phase (receiver stall) runs with no idling, and
    // the combined phase only idles the sender.
    int idle_plan[4] = '{0, 75, 0, 23};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    trial_division_number_classifier dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .number         (number),
        .done           (done),
        .prime_flag     (prime_flag),
        .composite_flag (composite_flag),
        .divisor_count  (divisor_count)
    );

    tdc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .number         (number),
        .done           (done),
        .prime_flag     (prime_flag),
        .composite_flag (composite_flag),
        .divisor_count  (divisor_count),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Watchdog: restart the count on every accepted item or result; end
    // the run if the block goes silent for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one item and hold it until the block takes it. Start is left
    // high on return so a back-to-back item never drops and raises it in
    // the same step; the drain lowers it, as does the next call when it idles.
    task automatic send_item(input logic cmd, input logic [NUMBER_WIDTH-1:0] num);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        number  <= num;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start and hold off until every pending result has come back.
    // Advance one edge first so the last acceptance is counted.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Random item. Primality tests roam the full 16-bit range, with extra
    // weight on small values, odd values and perfect squares that sit right
    // on the sqrt bound. Counts stay small: each one sweeps floor(n/2) trial
    // divisors.
    task automatic send_random_item();
        logic                    cmd;
        logic [NUMBER_WIDTH-1:0] num;
        int unsigned             root;
        cmd = 1'($urandom_range(0, 1));
        if (cmd == CMD_PRIME)
        begin
            case ($urandom_range(0, 3))
                0: num = NUMBER_WIDTH'($urandom_range(0, 64));
                1: num = NUMBER_WIDTH'($urandom | 1);
                2:
                begin
                    root = $urandom_range(2, 255);
                    num  = NUMBER_WIDTH'(root * root);
                end
                default: num = NUMBER_WIDTH'($urandom);
            endcase
        end
        else if ($urandom_range(0, 4) == 0)
            num = NUMBER_WIDTH'($urandom_range(512, 2047));
        else
            num = NUMBER_WIDTH'($urandom_range(0, 511));
        send_item(cmd, num);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_PRIME;
        number          = '0;
        sender_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Primality: zero and one (neither), two and three (no trial
        // divisor), small composites, perfect squares on the bound, the
        // largest 16-bit prime, all ones, and alternating bit patterns.
        send_item(CMD_PRIME, 16'd0);
        send_item(CMD_PRIME, 16'd1);
        send_item(CMD_PRIME, 16'd2);
        send_item(CMD_PRIME, 16'd3);
        send_item(CMD_PRIME, 16'd4);
        send_item(CMD_PRIME, 16'd5);
        send_item(CMD_PRIME, 16'd9);
        send_item(CMD_PRIME, 16'd121);
        send_item(CMD_PRIME, 16'd65025);
        send_item(CMD_PRIME, 16'd65521);
        send_item(CMD_PRIME, 16'hFFFF);
        send_item(CMD_PRIME, 16'h8000);
        send_item(CMD_PRIME, 16'hAAAA);
        send_item(CMD_PRIME, 16'h5555);

        // Counts: zero (empty range), one, tiny values, highly composite
        // values, and the widest sweep at all ones.
        send_item(CMD_COUNT, 16'd0);
        send_item(CMD_COUNT, 16'd1);
        send_item(CMD_COUNT, 16'd2);
        send_item(CMD_COUNT, 16'd3);
        send_item(CMD_COUNT, 16'd12);
        send_item(CMD_COUNT, 16'd720);
        send_item(CMD_COUNT, 16'd5040);
        send_item(CMD_COUNT, 16'hFFFF);

        // Pause the sender until the directed results are all back.
        wait_for_results();

        foreach (idle_plan[p])
        begin
            sender_idle_pct = idle_plan[p];
            repeat (ITEMS_PER_PHASE) send_random_item();
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tdc_pkg.sv
hdl/tdc_div.sv
hdl/trial_division_number_classifier.sv
dv/tdc_checker.sv
dv/trial_division_number_classifier_test.sv
